FILE: rtl/clst_pkg.sv
// Package for the cube layer scan and frame timer block.
// Types, codes and constants shared by every rtl file; no dependencies.
package clst_pkg;

  localparam int LAYERS       = 4;
  localparam int TICKS_PER_MS = 10;
  localparam int LOCKOUT_MS   = 200;
  localparam int POT_SPAN     = 511;
  localparam int FRAME_LAYERS = 4;   // layers held in the 64 frame bits

  localparam int LAYER_W    = $clog2(LAYERS);
  localparam int DIV5_MUL   = 52429; // ceil(2^18 / 5), exact for 16-bit dividends
  localparam int DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_TICK = 2'd1,
    ACT_NEXT = 2'd2,
    ACT_PREV = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_TIME = 2'd1,
    EV_NEXT = 2'd2,
    EV_PREV = 2'd3
  } event_e;

  typedef struct packed {
    action_e     action;
    logic [63:0] frame_bits;
    logic [15:0] base_duration;
    logic [9:0]  pot_level;
  } in_word_t;

  typedef struct packed {
    logic       shift_valid;
    logic [7:0] layer_select;
    logic [7:0] data_high;
    logic [7:0] data_low;
    event_e     frame_event;
  } out_word_t;

  // word after the range split: low end and span of the duration line
  typedef struct packed {
    in_word_t    word;
    logic [18:0] lo;
    logic [18:0] diff;
    logic [8:0]  q;
  } span_word_t;

  typedef struct packed {
    in_word_t    word;
    logic [18:0] lo;
    logic [26:0] prod;
  } prod_word_t;

  typedef struct packed {
    in_word_t    word;
    logic [18:0] lo;
    logic [18:0] quot;
  } quot_word_t;

endpackage

FILE: rtl/clst_scale.sv
// Duration scaling pipeline: range split, product, divide by 511.
// Depends on clst_pkg.
module clst_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                word_valid_i,
  input  clst_pkg::in_word_t  word_i,
  output logic                word_ready_o,
  output logic                quot_valid_o,
  output clst_pkg::quot_word_t quot_o,
  input  logic                quot_ready_i
);
  import clst_pkg::*;

  span_word_t span_q, span_d;
  prod_word_t prod_q, prod_d;
  quot_word_t quot_q, quot_d;
  logic       span_v_q, prod_v_q, quot_v_q;
  logic       span_rdy, prod_rdy, quot_rdy;

  logic [31:0] d5_full;
  logic [15:0] d5;
  logic [18:0] dur;
  logic [27:0] sum;
  logic [18:0] qe;
  logic [27:0] rem;

  assign quot_rdy     = !quot_v_q || quot_ready_i;
  assign prod_rdy     = !prod_v_q || quot_rdy;
  assign span_rdy     = !span_v_q || prod_rdy;
  assign word_ready_o = span_rdy;

  // split: p >= 512 runs D down to D/5, below it 5D down to D
  always_comb begin
    dur      = 19'(word_i.base_duration);
    d5_full  = 32'(word_i.base_duration) * 32'(DIV5_MUL);
    d5       = 16'(d5_full >> DIV5_SHIFT);
    span_d.word = word_i;
    span_d.q    = word_i.pot_level[8:0];
    if (word_i.pot_level[9]) begin
      span_d.lo   = dur;
      span_d.diff = dur - 19'(d5);
    end else begin
      span_d.lo   = (dur << 2) + dur;
      span_d.diff = dur << 2;
    end
  end

  always_comb begin
    prod_d.word = span_q.word;
    prod_d.lo   = span_q.lo;
    prod_d.prod = 27'(28'(span_q.q) * 28'(span_q.diff));
  end

  // m/511 via m*(1 + 2^-9 + 2^-18) >> 9, low by at most one, then one fix-up
  always_comb begin
    sum  = 28'(prod_q.prod) + 28'(prod_q.prod >> 9) + 28'(prod_q.prod >> 18);
    qe   = 19'(sum >> 9);
    rem  = 28'(prod_q.prod) - (28'(qe) << 9) + 28'(qe);
    quot_d.word = prod_q.word;
    quot_d.lo   = prod_q.lo;
    quot_d.quot = qe + 19'(rem >= 28'(POT_SPAN));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_v_q <= 1'b0;
      prod_v_q <= 1'b0;
      quot_v_q <= 1'b0;
    end else begin
      if (span_rdy) span_v_q <= word_valid_i;
      if (prod_rdy) prod_v_q <= span_v_q;
      if (quot_rdy) quot_v_q <= prod_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (span_rdy && word_valid_i) span_q <= span_d;
    if (prod_rdy && span_v_q)     prod_q <= prod_d;
    if (quot_rdy && prod_v_q)     quot_q <= quot_d;
  end

  assign quot_valid_o = quot_v_q;
  assign quot_o       = quot_q;

endmodule

FILE: rtl/clst_core.sv
// Scan and frame timer state, result register.
// Depends on clst_pkg.
module clst_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 quot_valid_i,
  input  clst_pkg::quot_word_t quot_i,
  output logic                 quot_ready_o,
  output logic                 out_valid_o,
  output clst_pkg::out_word_t  out_word_o,
  input  logic                 out_stall_i
);
  import clst_pkg::*;

  logic [63:0]        frame_q, frame_d;
  logic [LAYER_W-1:0] layer_q, layer_d;
  logic [3:0]         presc_q, presc_d;
  logic [15:0]        ms_q, ms_d;
  logic [15:0]        start_q, start_d;
  logic [15:0]        scaled_q, scaled_d;
  logic               run_q, run_d;
  logic [15:0]        last_next_q, last_next_d;
  logic [15:0]        last_prev_q, last_prev_d;
  logic [1:0]         pend_q, pend_d;
  logic               out_v_q;
  out_word_t          out_q, out_d;
  logic               take;

  logic [15:0]        scaled_new;
  logic [2:0]         lay3;
  logic [5:0]         sh;
  logic [LAYER_W:0]   lay_inc;
  logic [15:0]        since_next, since_prev;

  assign quot_ready_o = !out_v_q || !out_stall_i;
  assign take         = quot_valid_i && quot_ready_o;
  assign scaled_new   = 16'(quot_i.lo - quot_i.quot);
  assign since_next   = ms_q - last_next_q;
  assign since_prev   = ms_q - last_prev_q;

  always_comb begin
    frame_d     = frame_q;
    layer_d     = layer_q;
    presc_d     = presc_q;
    ms_d        = ms_q;
    start_d     = start_q;
    scaled_d    = scaled_q;
    run_d       = run_q;
    last_next_d = last_next_q;
    last_prev_d = last_prev_q;
    pend_d      = pend_q;
    out_d       = '0;
    out_d.frame_event = EV_NONE;
    lay3    = 3'(layer_q);
    sh      = {lay3[1:0], 4'b0000};
    lay_inc = (LAYER_W + 1)'(layer_q) + 1'b1;

    case (quot_i.word.action)
      ACT_LOAD: begin
        frame_d  = quot_i.word.frame_bits;
        scaled_d = scaled_new;
        start_d  = ms_q;
        run_d    = 1'b1;
        if (pend_q[1]) begin
          pend_d[1] = 1'b0;
          if (since_prev > 16'(LOCKOUT_MS)) begin
            last_prev_d       = ms_q;
            run_d             = 1'b0;
            out_d.frame_event = EV_PREV;
          end
        end
        if (out_d.frame_event == EV_NONE && pend_q[0]) begin
          pend_d[0] = 1'b0;
          if (since_next > 16'(LOCKOUT_MS)) begin
            last_next_d       = ms_q;
            run_d             = 1'b0;
            out_d.frame_event = EV_NEXT;
          end
        end
        // zero elapsed time: only a zero duration ends the frame at once
        if (out_d.frame_event == EV_NONE && scaled_new == 16'd0) begin
          run_d             = 1'b0;
          out_d.frame_event = EV_TIME;
        end
      end
      ACT_TICK: begin
        out_d.shift_valid  = 1'b1;
        out_d.layer_select = ~(8'd1 << lay3);
        if (lay3 < 3'(FRAME_LAYERS)) begin
          out_d.data_low  = frame_q[sh +: 8];
          out_d.data_high = frame_q[6'(sh + 6'd8) +: 8];
        end
        layer_d = (lay_inc >= (LAYER_W + 1)'(LAYERS)) ? '0 : LAYER_W'(lay_inc);
        presc_d = presc_q + 4'd1;
        if (presc_d == 4'(TICKS_PER_MS) || presc_d == 4'd0) begin
          presc_d = 4'd0;
          ms_d    = ms_q + 16'd1;
        end
        if (run_q && (16'(ms_d - start_q) >= scaled_q)) begin
          run_d             = 1'b0;
          out_d.frame_event = EV_TIME;
        end
      end
      ACT_NEXT: begin
        if (!run_q) begin
          pend_d[0] = 1'b1;
        end else if (since_next > 16'(LOCKOUT_MS)) begin
          last_next_d       = ms_q;
          run_d             = 1'b0;
          out_d.frame_event = EV_NEXT;
        end
      end
      ACT_PREV: begin
        if (!run_q) begin
          pend_d[1] = 1'b1;
        end else if (since_prev > 16'(LOCKOUT_MS)) begin
          last_prev_d       = ms_q;
          run_d             = 1'b0;
          out_d.frame_event = EV_PREV;
        end
      end
      default: begin
        out_d.frame_event = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      layer_q     <= '0;
      presc_q     <= '0;
      ms_q        <= '0;
      start_q     <= '0;
      scaled_q    <= '0;
      run_q       <= 1'b0;
      last_next_q <= '0;
      last_prev_q <= '0;
      pend_q      <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (quot_ready_o) out_v_q <= quot_valid_i;
      if (take) begin
        frame_q     <= frame_d;
        layer_q     <= layer_d;
        presc_q     <= presc_d;
        ms_q        <= ms_d;
        start_q     <= start_d;
        scaled_q    <= scaled_d;
        run_q       <= run_d;
        last_next_q <= last_next_d;
        last_prev_q <= last_prev_d;
        pend_q      <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  a_presc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    presc_q < 4'(TICKS_PER_MS))
    else $error("prescaler out of range");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && quot_i.word.action == ACT_TICK) |=> (out_v_q && out_q.shift_valid))
    else $error("tick without shift result");

  a_event_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && out_d.frame_event != EV_NONE) |=> !run_q)
    else $error("frame still running after frame event");

  a_prev_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && out_d.frame_event == EV_PREV) |=> (last_prev_q == ms_q))
    else $error("prev press not time stamped");
`endif

endmodule

FILE: rtl/cube_layer_scan_frame_timer_top.sv
// A word passes the input, span, product, quotient and result registers in turn.
// Throughput: one word per cycle while out_stall_i is low; input register, three
// scaling stages, result. The stall chain lets a new word in while a finished
// result waits downstream. Reset: asynchronous, active low; valid flags and control
// state clear at once, data registers are not reset; no clearing pass, the block
// takes words as soon as reset is released. Top level of the cube layer scan and
// frame timer; uses clst_pkg, clst_scale and clst_core.
module cube_layer_scan_frame_timer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  clst_pkg::in_word_t  in_word_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output clst_pkg::out_word_t out_word_o,
  input  logic                out_stall_i
);
  import clst_pkg::*;

  // input register
  in_word_t   in_q;
  logic       in_v_q;
  logic       in_rdy;
  logic       scale_rdy;

  // scaled duration and the word it belongs to
  quot_word_t quot;
  logic       quot_v;
  logic       quot_rdy;

  // stage frees up when empty or when its word moves on this edge
  assign in_rdy     = !in_v_q || scale_rdy;
  assign in_stall_o = !in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_rdy) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_valid_i) in_q <= in_word_i;
  end

  // load scaling runs on every word; only a load uses the result
  clst_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (in_v_q),
    .word_i       (in_q),
    .word_ready_o (scale_rdy),
    .quot_valid_o (quot_v),
    .quot_o       (quot),
    .quot_ready_i (quot_rdy)
  );

  // scan, millisecond count, lockout, pending presses and result word
  clst_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quot_valid_i (quot_v),
    .quot_i       (quot),
    .quot_ready_o (quot_rdy),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

FILE: test/cube_layer_scan_frame_timer_top_tb.sv
// Testbench for cube_layer_scan_frame_timer_top: self-checking, stand-alone.
// Uses clst_pkg for the word types and codes; a predictor in this file tracks
// the scan, millisecond timer, lockout and held-press state of the block.
`timescale 1ns / 1ps

module cube_layer_scan_frame_timer_top_tb;
  import clst_pkg::*;

  localparam int POT_MID      = 512;
  localparam int SCALE_FACTOR = 5;
  localparam int STUCK_LIMIT  = 3000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES  = 16;    // idle cycles run after the last result is checked

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  in_word_t  in_word_i;
  logic      in_stall_o;
  logic      out_valid_o;
  out_word_t out_word_o;
  logic      out_stall_i;

  cube_layer_scan_frame_timer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o),
    .out_stall_i(out_stall_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between the stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  in_word_t  pending_words[$];   // words waiting to be offered to the block
  out_word_t scan_results[$];    // predicted result words, oldest first
  bit        word_taken;         // set at the edge the offered word was accepted
  int        idle_pct = 28;      // chance per cycle that a side idles or stalls
  int        stuck_cycles;
  int        fail_count;
  int        load_count, tick_count, press_count;
  int        end_count[4];       // frame ends by event code

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of everything the block keeps
  // ---------------------------------------------------------------------------
  logic [63:0] cube_frame;
  int unsigned layer_at;
  logic [3:0]  prescale;
  logic [15:0] ms_now;
  logic [15:0] frame_t0;
  logic [15:0] frame_len;
  bit          frame_live;
  logic [15:0] next_press_ms;
  logic [15:0] prev_press_ms;
  bit          held_next;
  bit          held_prev;

  // Duration line: above mid-scale the pot shortens the frame down to D/5,
  // below it lengthens it up to 5*D. Signed truncating divide, 16-bit wrap.
  function automatic logic [15:0] scaled_len(logic [15:0] dur, logic [9:0] pot);
    longint lo, hi, q, v;
    if (pot >= POT_MID) begin
      lo = longint'(dur);
      hi = longint'(dur) / SCALE_FACTOR;
      q  = longint'(pot) - POT_MID;
    end else begin
      lo = longint'(dur) * SCALE_FACTOR;
      hi = longint'(dur);
      q  = longint'(pot);
    end
    v = (q * (hi - lo)) / POT_SPAN + lo;
    return v[15:0];
  endfunction

  // Milliseconds since a mark, modulo 2^16.
  function automatic logic [15:0] ms_since(logic [15:0] mark);
    return ms_now - mark;
  endfunction

  // A press ends the frame only outside the lockout window of its button.
  function automatic event_e press_taken(bit is_prev);
    if (is_prev) begin
      if (ms_since(prev_press_ms) > LOCKOUT_MS) begin
        prev_press_ms = ms_now;
        frame_live    = 1'b0;
        return EV_PREV;
      end
    end else begin
      if (ms_since(next_press_ms) > LOCKOUT_MS) begin
        next_press_ms = ms_now;
        frame_live    = 1'b0;
        return EV_NEXT;
      end
    end
    return EV_NONE;
  endfunction

  function automatic event_e time_over();
    if (frame_live && ms_since(frame_t0) >= frame_len) begin
      frame_live = 1'b0;
      return EV_TIME;
    end
    return EV_NONE;
  endfunction

  // One accepted input word in, one result word out.
  function automatic out_word_t scan_and_time(in_word_t w);
    out_word_t   r;
    int unsigned lyr;
    r = '0;
    case (w.action)
      ACT_LOAD: begin
        cube_frame = w.frame_bits;
        frame_len  = scaled_len(w.base_duration, w.pot_level);
        frame_t0   = ms_now;
        frame_live = 1'b1;
        // held prev is looked at first; a taken prev leaves next held
        if (held_prev) begin
          held_prev     = 1'b0;
          r.frame_event = press_taken(1'b1);
        end
        if (r.frame_event == EV_NONE && held_next) begin
          held_next     = 1'b0;
          r.frame_event = press_taken(1'b0);
        end
        if (r.frame_event == EV_NONE) r.frame_event = time_over();
      end
      ACT_TICK: begin
        lyr            = layer_at;
        r.shift_valid  = 1'b1;
        r.layer_select = ~(8'd1 << lyr);
        if (lyr < FRAME_LAYERS) begin
          r.data_low  = cube_frame[16*lyr +: 8];
          r.data_high = cube_frame[16*lyr+8 +: 8];
        end
        layer_at = (lyr + 1 >= LAYERS) ? 0 : lyr + 1;
        prescale = prescale + 4'd1;
        if (prescale == TICKS_PER_MS || prescale == 4'd0) begin
          prescale = 4'd0;
          ms_now   = ms_now + 16'd1;
        end
        r.frame_event = time_over();
      end
      default: begin
        // next or prev button
        if (frame_live) r.frame_event = press_taken(w.action == ACT_PREV);
        else if (w.action == ACT_PREV) held_prev = 1'b1;
        else held_next = 1'b1;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the head of pending_words at the falling edge. A word once
  // offered stays put until it is taken; valid never looks at stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_word_i  <= pending_words[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      word_taken = 1'b0;
      out_stall_i <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, predict each accepted input word and check
  // each accepted result word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t got;
    bit        moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = scan_and_time(in_word_i);
        scan_results.push_back(want);
        void'(pending_words.pop_front());
        word_taken = 1'b1;
        moved      = 1'b1;
        case (in_word_i.action)
          ACT_LOAD: load_count++;
          ACT_TICK: tick_count++;
          default:  press_count++;
        endcase
        end_count[want.frame_event]++;
      end
      if (out_valid_o && !out_stall_i) begin
        got   = out_word_o;
        moved = 1'b1;
        if (scan_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word with nothing predicted: %h", $realtime, got);
        end else begin
          want = scan_results.pop_front();
          if (got.shift_valid  !== want.shift_valid  ||
              got.layer_select !== want.layer_select ||
              got.data_high    !== want.data_high    ||
              got.data_low     !== want.data_low     ||
              got.frame_event  !== want.frame_event) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: exp vld=%b sel=%h hi=%h lo=%h ev=%0d, got %b %h %h %h %0d",
                       $realtime, want.shift_valid, want.layer_select, want.data_high,
                       want.data_low, want.frame_event, got.shift_valid, got.layer_select,
                       got.data_high, got.data_low, got.frame_event);
          end
        end
      end
      // watchdog only runs while something is still owed
      if (moved || (pending_words.size() == 0 && scan_results.size() == 0))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout: %0d words waiting, %0d results owed",
                 pending_words.size(), scan_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_word(action_e a, logic [63:0] bits, logic [15:0] dur,
                            logic [9:0] pot);
    in_word_t w;
    w.action        = a;
    w.frame_bits    = bits;
    w.base_duration = dur;
    w.pot_level     = pot;
    pending_words.push_back(w);
  endtask

  function automatic logic [63:0] any_bits();
    return {$urandom, $urandom};
  endfunction

  // Random payload on a button or tick word: ignored there, but keeps every
  // bit of the load fields toggling.
  task automatic queue_noisy(action_e a);
    queue_word(a, any_bits(), 16'($urandom), 10'($urandom));
  endtask

  // One random step. Loads mostly use very short durations so frames run
  // out within the few ms the ticks of the run advance.
  task automatic queue_episode();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      queue_word(ACT_LOAD, any_bits(), 16'($urandom_range(0, 8)), 10'($urandom));
    else if (pick < 13)
      queue_word(ACT_LOAD, any_bits(), 16'($urandom), 10'($urandom));
    else if (pick < 60)
      queue_noisy(ACT_TICK);
    else if (pick < 72)
      queue_noisy(ACT_NEXT);
    else if (pick < 84)
      queue_noisy(ACT_PREV);
    else begin
      n = $urandom_range(2, 6);
      repeat (n) queue_noisy(ACT_TICK);
    end
  endtask

  task automatic wait_words_gone();
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_all_done();
    while (pending_words.size() != 0 || scan_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    out_stall_i  = 1'b0;
    word_taken   = 1'b0;
    stuck_cycles = 0;
    fail_count   = 0;
    cube_frame    = '0;
    layer_at      = 0;
    prescale      = '0;
    ms_now        = '0;
    frame_t0      = '0;
    frame_len     = '0;
    frame_live    = 1'b0;
    next_press_ms = '0;
    prev_press_ms = '0;
    held_next     = 1'b0;
    held_prev     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part ---
    // layer scan with nothing loaded yet
    queue_word(ACT_TICK, '1, '1, '1);
    // presses with no frame running are held for the next load
    queue_word(ACT_PREV, '0, '0, '0);
    queue_word(ACT_NEXT, '1, '0, '1);
    // both held presses fall in the lockout and are dropped; 5x wraps 16 bits
    queue_word(ACT_LOAD, '1, 16'hFFFF, 10'd0);
    repeat (4) queue_word(ACT_TICK, '0, '0, '0);
    // presses inside the lockout while running: dropped
    queue_word(ACT_NEXT, '0, '0, '0);
    queue_word(ACT_PREV, '0, '0, '0);
    // zero duration ends at once
    queue_word(ACT_LOAD, 64'h0123_4567_89AB_CDEF, 16'd0, 10'd1023);
    // tick with no frame running
    queue_word(ACT_TICK, '0, '0, '0);
    // pot at both sides of mid-scale; load on top of a running frame
    queue_word(ACT_LOAD, 64'hAAAA_5555_F0F0_0F0F, 16'd100, 10'd511);
    queue_word(ACT_LOAD, 64'h5555_AAAA_0F0F_F0F0, 16'd100, 10'd512);
    queue_word(ACT_LOAD, '1, 16'hFFFF, 10'd1023);
    // D/5 rounds to zero: scaled length zero, times out on load
    queue_word(ACT_LOAD, 64'h8000_0000_0000_0001, 16'd1, 10'd1023);
    queue_word(ACT_LOAD, '0, 16'd7, 10'h155);
    queue_word(ACT_LOAD, 64'h8000_0000_0000_0001, 16'd3, 10'h2AA);
    repeat (4) queue_word(ACT_TICK, '0, '0, '0);

    // sender holds off until every predicted result is back
    wait_all_done();

    // --- random part: noisy, then a stretch with no idling, then noisy ---
    repeat (200) queue_episode();
    wait_words_gone();
    idle_pct = 0;
    repeat (180) queue_episode();
    wait_words_gone();
    idle_pct = 28;
    repeat (240) queue_episode();

    wait_all_done();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d loads, %0d ticks, %0d button words across %0d ms of scan",
             load_count, tick_count, press_count, ms_now);
    $display("Frame ends: %0d time over, %0d next, %0d prev; %0d bad result words",
             end_count[EV_TIME], end_count[EV_NEXT], end_count[EV_PREV], fail_count);
    if (fail_count == 0 && scan_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/clst_pkg.sv
rtl/clst_scale.sv
rtl/clst_core.sv
rtl/cube_layer_scan_frame_timer_top.sv
test/cube_layer_scan_frame_timer_top_tb.sv
